@@ rtl/matrix3x3_inverse_unit_macros.svh @@
// Assertion helpers used by matrix3x3_inverse_unit. Clock i_clk and reset i_rst_n are
// taken from the module that uses them.
`ifndef MATRIX3X3_INVERSE_UNIT_MACROS_SVH
`define MATRIX3X3_INVERSE_UNIT_MACROS_SVH

// same-cycle implication
`define M3I_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define M3I_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/m3i_pkg.sv @@
package m3i_pkg;

    localparam int ELEM_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int NUM_ELEM       = 9;
    localparam int FRONT_STAGES   = 6;

    typedef logic [3:0] t_idx;

    // cofactor k = a[i0]*a[i1] - a[i2]*a[i3], row-major element indexes
    localparam t_idx COF_IDX [NUM_ELEM][4] = '{
        '{4'd4, 4'd8, 4'd7, 4'd5}, '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
        '{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd3, 4'd2, 4'd0, 4'd5},
        '{4'd3, 4'd7, 4'd6, 4'd4}, '{4'd6, 4'd1, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd3, 4'd1}
    };

    typedef struct packed {
        logic                singular;
        logic [NUM_ELEM-1:0] neg;
        logic [NUM_ELEM-1:0] big;
    } t_div_ctl;

endpackage

@@ rtl/m3i_ifs.sv @@
interface m3i_in_if #(parameter int W = m3i_pkg::ELEM_WIDTH_DEF);
    logic valid;
    logic ready;
    logic signed [W-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;

    modport source (output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                    input ready);
    modport sink   (input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                    output ready);
endinterface

interface m3i_out_if #(parameter int W = m3i_pkg::ELEM_WIDTH_DEF);
    logic valid;
    logic ready;
    logic signed [W-1:0] inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22;
    logic singular;
    logic overflow;

    modport source (output valid, inv00, inv01, inv02, inv10, inv11, inv12,
                    inv20, inv21, inv22, singular, overflow, input ready);
    modport sink   (input valid, inv00, inv01, inv02, inv10, inv11, inv12,
                    inv20, inv21, inv22, singular, overflow, output ready);
endinterface

@@ rtl/matrix3x3_inverse_unit.sv @@
// 3x3 matrix inverse, signed fixed point (Q16.16 by default).
// Input channel i_in: one item is a whole matrix, a00..a22 row-major.
// Output channel o_out: one item per matrix, inv00..inv22 row-major,
// plus singular (determinant exactly zero, all elements zero) and
// overflow (some element clipped to the signed element range).
// Both channels move an item on a clock edge with valid and ready high.
// Quotients are exact and truncated toward zero.
// Throughput: one item per cycle while the skid register is empty.
// Stages from the accepting edge to o_out.valid: six setup stages
// (cofactor products, cofactors, determinant partial products, determinant,
// magnitudes, remainder seed), one restoring divider stage per quotient bit
// for all nine lanes in parallel, and a saturation stage.
// A two-entry output: when the receiver stalls, the last stage spills into
// a skid register and the pipeline keeps taking one more item; while that
// register is full i_in.ready is low and the whole pipeline holds.
// Reset (synchronous, active low) clears all valid bits; items in flight
// are dropped.
module matrix3x3_inverse_unit #(
    parameter int ELEM_WIDTH = m3i_pkg::ELEM_WIDTH_DEF,
    parameter int FRAC_BITS  = m3i_pkg::FRAC_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    m3i_in_if.sink    i_in,
    m3i_out_if.source o_out
);
    import m3i_pkg::*;

    `include "matrix3x3_inverse_unit_macros.svh"

    localparam int W   = ELEM_WIDTH;
    localparam int DW  = 3*W+3;
    localparam int NST = FRONT_STAGES + W + 1;

    logic signed [W-1:0] w_a [NUM_ELEM];

    // per-stage valid bits, advance together
    logic [NST-1:0] r_vld;
    logic           w_en;

    // divider chain: index 0 is the front output, index W the last step
    logic [DW-1:0] w_dabs [W+1];
    logic [DW-1:0] w_rem  [W+1][NUM_ELEM];
    logic [W-1:0]  w_nlow [W+1][NUM_ELEM];
    logic [W-1:0]  w_q    [W+1][NUM_ELEM];
    t_div_ctl      w_ctl  [W+1];

    logic signed [W-1:0] w_inv [NUM_ELEM];
    logic                w_sing;
    logic                w_ovf;

    // skid register
    logic                r_skid_vld;
    logic signed [W-1:0] r_skid_inv [NUM_ELEM];
    logic                r_skid_sing;
    logic                r_skid_ovf;

    logic signed [W-1:0] w_out_inv [NUM_ELEM];

    assign w_a[0] = i_in.a00;
    assign w_a[1] = i_in.a01;
    assign w_a[2] = i_in.a02;
    assign w_a[3] = i_in.a10;
    assign w_a[4] = i_in.a11;
    assign w_a[5] = i_in.a12;
    assign w_a[6] = i_in.a20;
    assign w_a[7] = i_in.a21;
    assign w_a[8] = i_in.a22;

    // pipeline moves whenever the skid register is free
    assign w_en       = !r_skid_vld;
    assign i_in.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NST-2:0], i_in.valid};
        end
    end

    m3i_front #(.W(W), .F(FRAC_BITS), .DW(DW)) u_front (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_a    (w_a),
        .o_dabs (w_dabs[0]),
        .o_rem  (w_rem[0]),
        .o_nlow (w_nlow[0]),
        .o_ctl  (w_ctl[0])
    );

    always_comb begin
        for (int k = 0; k < NUM_ELEM; k++) begin
            w_q[0][k] = '0;
        end
    end

    for (genvar s = 0; s < W; s++) begin : g_div
        m3i_div_step #(.W(W), .DW(DW)) u_step (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_dabs (w_dabs[s]),
            .i_rem  (w_rem[s]),
            .i_nlow (w_nlow[s]),
            .i_q    (w_q[s]),
            .i_ctl  (w_ctl[s]),
            .o_dabs (w_dabs[s+1]),
            .o_rem  (w_rem[s+1]),
            .o_nlow (w_nlow[s+1]),
            .o_q    (w_q[s+1]),
            .o_ctl  (w_ctl[s+1])
        );
    end

    m3i_sat #(.W(W)) u_sat (
        .i_clk      (i_clk),
        .i_en       (w_en),
        .i_q        (w_q[W]),
        .i_ctl      (w_ctl[W]),
        .o_inv      (w_inv),
        .o_singular (w_sing),
        .o_overflow (w_ovf)
    );

    // last stage spills into the skid register when the receiver stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (o_out.ready) begin
                r_skid_vld <= 1'b0;
            end
        end else if (r_vld[NST-1] && !o_out.ready) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_vld) begin
            r_skid_inv  <= w_inv;
            r_skid_sing <= w_sing;
            r_skid_ovf  <= w_ovf;
        end
    end

    assign o_out.valid    = r_skid_vld || r_vld[NST-1];
    assign w_out_inv      = r_skid_vld ? r_skid_inv : w_inv;
    assign o_out.singular = r_skid_vld ? r_skid_sing : w_sing;
    assign o_out.overflow = r_skid_vld ? r_skid_ovf : w_ovf;
    assign o_out.inv00    = w_out_inv[0];
    assign o_out.inv01    = w_out_inv[1];
    assign o_out.inv02    = w_out_inv[2];
    assign o_out.inv10    = w_out_inv[3];
    assign o_out.inv11    = w_out_inv[4];
    assign o_out.inv12    = w_out_inv[5];
    assign o_out.inv20    = w_out_inv[6];
    assign o_out.inv21    = w_out_inv[7];
    assign o_out.inv22    = w_out_inv[8];

    `M3I_ASSERT_IMP(a_sing_no_ovf, o_out.valid && o_out.singular, !o_out.overflow, "singular item flagged overflow")
    `M3I_ASSERT_IMP(a_sing_zero, o_out.valid && o_out.singular, o_out.inv00 == 0 && o_out.inv11 == 0 && o_out.inv22 == 0 && o_out.inv01 == 0 && o_out.inv10 == 0, "singular item has nonzero element")
    `M3I_ASSERT_NXT(a_skid_fill, r_vld[NST-1] && !o_out.ready && !r_skid_vld, r_skid_vld, "stalled result not held in skid register")

endmodule

@@ rtl/m3i_front.sv @@
module m3i_front #(
    parameter int W  = m3i_pkg::ELEM_WIDTH_DEF,
    parameter int F  = m3i_pkg::FRAC_BITS_DEF,
    parameter int DW = 3*W+3
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [W-1:0]      i_a    [m3i_pkg::NUM_ELEM],
    output logic [DW-1:0]            o_dabs,
    output logic [DW-1:0]            o_rem  [m3i_pkg::NUM_ELEM],
    output logic [W-1:0]             o_nlow [m3i_pkg::NUM_ELEM],
    output m3i_pkg::t_div_ctl        o_ctl
);
    import m3i_pkg::*;

    localparam int PW = 2*W;
    localparam int CW = 2*W+1;
    localparam int MW = 2*W+1;
    localparam int NW = MW+2*F;
    localparam int HW = NW-W;
    localparam int XW = (HW > DW) ? HW : DW;

    // stage 1: cofactor products
    logic signed [PW-1:0] r_p0 [NUM_ELEM];
    logic signed [PW-1:0] r_p1 [NUM_ELEM];
    logic signed [W-1:0]  r_a1 [3];
    // stage 2: cofactors
    logic signed [CW-1:0] r_cof2 [NUM_ELEM];
    logic signed [W-1:0]  r_a2 [3];
    // stage 3: determinant partial products
    logic signed [2*W:0]  r_plo [3];
    logic signed [2*W:0]  r_phi [3];
    logic signed [CW-1:0] r_cof3 [NUM_ELEM];
    // stage 4: determinant
    logic signed [DW-1:0] r_det;
    logic signed [CW-1:0] r_cof4 [NUM_ELEM];
    // stage 5: magnitudes
    logic [DW-1:0]        r_dabs5;
    logic [MW-1:0]        r_mag [NUM_ELEM];
    logic [NUM_ELEM-1:0]  r_neg5;
    logic                 r_sing5;
    // stage 6: division setup
    logic [DW-1:0]        r_dabs6;
    logic [DW-1:0]        r_rem [NUM_ELEM];
    logic [W-1:0]         r_nlow [NUM_ELEM];
    t_div_ctl             r_ctl;

    logic signed [PW-1:0] w_m0 [NUM_ELEM];
    logic signed [PW-1:0] w_m1 [NUM_ELEM];
    logic signed [W:0]    w_lo [3];
    logic signed [W:0]    w_hi [3];
    logic signed [DW-1:0] w_det;
    logic [NW-1:0]        w_n  [NUM_ELEM];
    logic [XW-1:0]        w_hx [NUM_ELEM];
    logic [NUM_ELEM-1:0]  w_big;

    always_comb begin
        for (int k = 0; k < NUM_ELEM; k++) begin
            w_m0[k] = i_a[COF_IDX[k][0]] * i_a[COF_IDX[k][1]];
            w_m1[k] = i_a[COF_IDX[k][2]] * i_a[COF_IDX[k][3]];
        end
        // split cofactor: unsigned low word, signed high part
        for (int j = 0; j < 3; j++) begin
            w_lo[j] = $signed({1'b0, r_cof2[3*j][W-1:0]});
            w_hi[j] = r_cof2[3*j][CW-1:W];
        end
        w_det = DW'(r_plo[0]) + (DW'(r_phi[0]) <<< W)
              + DW'(r_plo[1]) + (DW'(r_phi[1]) <<< W)
              + DW'(r_plo[2]) + (DW'(r_phi[2]) <<< W);
        // numerator = |cof| * 2^(2F); its bits from bit W upward seed the remainder
        for (int k = 0; k < NUM_ELEM; k++) begin
            w_n[k]   = {r_mag[k], {(2*F){1'b0}}};
            w_hx[k]  = XW'(w_n[k][NW-1:W]);
            w_big[k] = w_hx[k] >= XW'(r_dabs5);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NUM_ELEM; k++) begin
                r_p0[k]   <= w_m0[k];
                r_p1[k]   <= w_m1[k];
                r_cof2[k] <= CW'(r_p0[k]) - CW'(r_p1[k]);
                r_cof3[k] <= r_cof2[k];
                r_cof4[k] <= r_cof3[k];
                r_mag[k]  <= r_cof4[k][CW-1] ? MW'(-r_cof4[k]) : MW'(r_cof4[k]);
                r_neg5[k] <= r_cof4[k][CW-1] ^ r_det[DW-1];
                r_rem[k]  <= w_hx[k][DW-1:0];
                r_nlow[k] <= w_n[k][W-1:0];
            end
            for (int j = 0; j < 3; j++) begin
                r_a1[j]  <= i_a[j];
                r_a2[j]  <= r_a1[j];
                r_plo[j] <= r_a2[j] * w_lo[j];
                r_phi[j] <= r_a2[j] * w_hi[j];
            end
            r_det        <= w_det;
            r_dabs5      <= r_det[DW-1] ? DW'(-r_det) : DW'(r_det);
            r_sing5      <= (r_det == '0);
            r_dabs6      <= r_dabs5;
            r_ctl.singular <= r_sing5;
            r_ctl.neg    <= r_neg5;
            r_ctl.big    <= w_big;
        end
    end

    assign o_dabs = r_dabs6;
    assign o_rem  = r_rem;
    assign o_nlow = r_nlow;
    assign o_ctl  = r_ctl;

endmodule

@@ rtl/m3i_div_step.sv @@
module m3i_div_step #(
    parameter int W  = m3i_pkg::ELEM_WIDTH_DEF,
    parameter int DW = 3*W+3
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [DW-1:0]      i_dabs,
    input  logic [DW-1:0]      i_rem  [m3i_pkg::NUM_ELEM],
    input  logic [W-1:0]       i_nlow [m3i_pkg::NUM_ELEM],
    input  logic [W-1:0]       i_q    [m3i_pkg::NUM_ELEM],
    input  m3i_pkg::t_div_ctl  i_ctl,
    output logic [DW-1:0]      o_dabs,
    output logic [DW-1:0]      o_rem  [m3i_pkg::NUM_ELEM],
    output logic [W-1:0]       o_nlow [m3i_pkg::NUM_ELEM],
    output logic [W-1:0]       o_q    [m3i_pkg::NUM_ELEM],
    output m3i_pkg::t_div_ctl  o_ctl
);
    import m3i_pkg::*;

    logic [DW:0]         w_t  [NUM_ELEM];
    logic [DW:0]         w_d  [NUM_ELEM];
    logic [NUM_ELEM-1:0] w_ge;

    // one restoring step per lane: bring down the next numerator bit
    always_comb begin
        for (int k = 0; k < NUM_ELEM; k++) begin
            w_t[k]  = {i_rem[k], i_nlow[k][W-1]};
            w_ge[k] = w_t[k] >= {1'b0, i_dabs};
            w_d[k]  = w_t[k] - {1'b0, i_dabs};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NUM_ELEM; k++) begin
                o_rem[k]  <= w_ge[k] ? w_d[k][DW-1:0] : w_t[k][DW-1:0];
                o_nlow[k] <= {i_nlow[k][W-2:0], 1'b0};
                o_q[k]    <= {i_q[k][W-2:0], w_ge[k]};
            end
            o_dabs <= i_dabs;
            o_ctl  <= i_ctl;
        end
    end

endmodule

@@ rtl/m3i_sat.sv @@
module m3i_sat #(
    parameter int W = m3i_pkg::ELEM_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [W-1:0]        i_q   [m3i_pkg::NUM_ELEM],
    input  m3i_pkg::t_div_ctl   i_ctl,
    output logic signed [W-1:0] o_inv [m3i_pkg::NUM_ELEM],
    output logic                o_singular,
    output logic                o_overflow
);
    import m3i_pkg::*;

    logic [W-1:0]        w_lim [NUM_ELEM];
    logic [W-1:0]        w_mag [NUM_ELEM];
    logic [NUM_ELEM-1:0] w_sat;

    always_comb begin
        for (int k = 0; k < NUM_ELEM; k++) begin
            w_lim[k] = i_ctl.neg[k] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
            w_sat[k] = i_ctl.big[k] || (i_q[k] > w_lim[k]);
            w_mag[k] = w_sat[k] ? w_lim[k] : i_q[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NUM_ELEM; k++) begin
                if (i_ctl.singular) begin
                    o_inv[k] <= '0;
                end else begin
                    o_inv[k] <= i_ctl.neg[k] ? $signed(-w_mag[k]) : $signed(w_mag[k]);
                end
            end
            o_singular <= i_ctl.singular;
            o_overflow <= !i_ctl.singular && (|w_sat);
        end
    end

endmodule

@@ bench/matrix3x3_inverse_unit_test.sv @@
module matrix3x3_inverse_unit_test;
    import m3i_pkg::*;

    localparam int EW = ELEM_WIDTH_DEF;
    localparam int FB = FRAC_BITS_DEF;
    localparam int WIDE = 256;
    localparam int LIMIT = 2000000;

    typedef logic signed [EW-1:0] t_elem;
    typedef struct {
        t_elem a [NUM_ELEM];
    } t_matrix;
    typedef struct {
        t_elem inv [NUM_ELEM];
        logic  singular;
        logic  overflow;
    } t_inverse;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    m3i_in_if  #(.W(EW)) in_ch ();
    m3i_out_if #(.W(EW)) out_ch ();

    matrix3x3_inverse_unit #(.ELEM_WIDTH(EW), .FRAC_BITS(FB)) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    t_inverse pending_inv [$];
    int       mismatches = 0;
    int       cycles = 0;
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;

    // Exact inverse: each element is trunc(cof * 2^(2*FB) / det), then clipped.
    function automatic t_inverse invert_matrix(t_matrix m);
        t_inverse r;
        logic signed [WIDE-1:0] e [NUM_ELEM];
        logic signed [WIDE-1:0] cof [NUM_ELEM];
        logic signed [WIDE-1:0] det, q;
        logic signed [WIDE-1:0] hi, lo;
        hi = (WIDE'(1) <<< (EW - 1)) - 1;
        lo = -(WIDE'(1) <<< (EW - 1));
        r.singular = 1'b0;
        r.overflow = 1'b0;
        for (int k = 0; k < NUM_ELEM; k++) e[k] = WIDE'(m.a[k]);
        for (int k = 0; k < NUM_ELEM; k++)
            cof[k] = e[COF_IDX[k][0]] * e[COF_IDX[k][1]]
                   - e[COF_IDX[k][2]] * e[COF_IDX[k][3]];
        det = e[0] * cof[0] + e[1] * cof[3] + e[2] * cof[6];
        if (det == 0) begin
            for (int k = 0; k < NUM_ELEM; k++) r.inv[k] = '0;
            r.singular = 1'b1;
            return r;
        end
        for (int k = 0; k < NUM_ELEM; k++) begin
            q = (cof[k] <<< (2 * FB)) / det;   // signed division truncates toward zero
            if (q > hi) begin
                q = hi;
                r.overflow = 1'b1;
            end else if (q < lo) begin
                q = lo;
                r.overflow = 1'b1;
            end
            r.inv[k] = q[EW-1:0];
        end
        return r;
    endfunction

    function automatic t_elem rand_elem();
        case ($urandom_range(0, 9))
            0: return t_elem'(32'h8000_0000);
            1: return t_elem'(32'h7fff_ffff);
            2, 3: return t_elem'($urandom);
            4: return t_elem'($signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000);
            5: return '0;
            6: return t_elem'(32'h0001_0000);
            default: return t_elem'($signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
        endcase
    endfunction

    // Directed rows; expected typed in where obvious, else predictor.
    typedef struct {
        t_matrix  m;
        logic     fixed_exp;
        t_inverse exp;
    } t_row;
    t_row directed [$];

    task automatic add_row(t_elem v [NUM_ELEM], logic fixed, t_inverse ex);
        t_row r;
        for (int k = 0; k < NUM_ELEM; k++) r.m.a[k] = v[k];
        r.fixed_exp = fixed;
        r.exp = ex;
        directed.push_back(r);
    endtask

    task automatic build_directed();
        t_inverse z, id;
        t_elem v [NUM_ELEM];
        for (int k = 0; k < NUM_ELEM; k++) z.inv[k] = '0;
        z.singular = 1'b1; z.overflow = 1'b0;
        id = z; id.singular = 1'b0;
        id.inv[0] = 32'h0001_0000; id.inv[4] = 32'h0001_0000; id.inv[8] = 32'h0001_0000;
        v = '{default: '0};                              add_row(v, 1'b1, z);
        v = '{default: 32'h7fff_ffff};                   add_row(v, 1'b1, z);
        v = '{default: 32'h8000_0000};                   add_row(v, 1'b1, z);
        v = '{default: '0}; v[0] = 32'h0001_0000; v[4] = 32'h0001_0000;
        v[8] = 32'h0001_0000;                            add_row(v, 1'b1, id);
        // tiny determinant: clips hard
        v = '{default: '0}; v[0] = 1; v[4] = 1; v[8] = 1; add_row(v, 1'b0, z);
        v[1] = 32'hffff_ffff;                            add_row(v, 1'b0, z);
        v = '{default: '0}; v[0] = 32'h8000_0000; v[4] = 32'h8000_0000;
        v[8] = 32'h8000_0000;                            add_row(v, 1'b0, z);
        v = '{default: '0}; v[0] = 32'h7fff_ffff; v[4] = 32'h7fff_ffff;
        v[8] = 32'h7fff_ffff;                            add_row(v, 1'b0, z);
        v = '{default: '0}; v[2] = 32'h0002_0000; v[4] = 32'hffff_0000;
        v[6] = 32'h0000_8000;                            add_row(v, 1'b0, z);
        v = '{32'h7fff_ffff, 32'h8000_0000, 0, 0, 32'h7fff_ffff, 32'h8000_0000,
              32'h8000_0000, 0, 32'h7fff_ffff};          add_row(v, 1'b0, z);
        v = '{1, 2, 3, 4, 5, 6, 7, 8, 10};               add_row(v, 1'b0, z);
        // rank-deficient, nonzero: two equal rows
        v = '{32'h0003_0000, 32'h0001_0000, 5, 32'h0003_0000, 32'h0001_0000, 5,
              32'h1234, 7, 9};                            add_row(v, 1'b1, z);
        v = '{32'hfffe_0000, 32'h0000_4000, 32'h0001_8000, 32'h0000_c000,
              32'hffff_0000, 32'h0003_0000, 32'h0002_0000, 32'h0000_2000,
              32'hfffd_0000};                             add_row(v, 1'b0, z);
        for (int n = 0; n < 6; n++) begin
            for (int k = 0; k < NUM_ELEM; k++) v[k] = rand_elem();
            add_row(v, 1'b0, z);
        end
    endtask

    // valid drops only in idle cycles, so back-to-back items keep it high
    task automatic send_matrix(t_matrix m);
        while (send_idle_pct > 0 && $urandom_range(1, 100) <= send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.a00 <= m.a[0]; in_ch.a01 <= m.a[1]; in_ch.a02 <= m.a[2];
        in_ch.a10 <= m.a[3]; in_ch.a11 <= m.a[4]; in_ch.a12 <= m.a[5];
        in_ch.a20 <= m.a[6]; in_ch.a21 <= m.a[7]; in_ch.a22 <= m.a[8];
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    // Queue the expectation before the item is sent.
    task automatic run_item(t_matrix m, logic fixed, t_inverse ex);
        pending_inv.push_back(fixed ? ex : invert_matrix(m));
        send_matrix(m);
    endtask

    // receiver: randomly stall ready
    always @(posedge i_clk) begin
        if (!i_rst_n) out_ch.ready <= 1'b0;
        else out_ch.ready <= ($urandom_range(1, 100) > recv_stall_pct);
    end

    // result checker
    always @(posedge i_clk) begin
        t_inverse ex;
        t_elem got [NUM_ELEM];
        logic bad;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = '{out_ch.inv00, out_ch.inv01, out_ch.inv02, out_ch.inv10, out_ch.inv11,
                    out_ch.inv12, out_ch.inv20, out_ch.inv21, out_ch.inv22};
            if (pending_inv.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result item");
            end else begin
                ex = pending_inv.pop_front();
                bad = (ex.singular !== out_ch.singular) || (ex.overflow !== out_ch.overflow);
                for (int k = 0; k < NUM_ELEM; k++) if (got[k] !== ex.inv[k]) bad = 1'b1;
                if (bad) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result mismatch: singular %b/%b overflow %b/%b",
                                 ex.singular, out_ch.singular, ex.overflow, out_ch.overflow);
                        for (int k = 0; k < NUM_ELEM; k++)
                            if (got[k] !== ex.inv[k])
                                $display("  inv[%0d] exp %h got %h", k, ex.inv[k], got[k]);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        t_matrix m;
        int phase_pct [4][2] = '{'{0, 0}, '{85, 0}, '{0, 85}, '{34, 34}};
        int tail;
        in_ch.valid = 1'b0;
        {in_ch.a00, in_ch.a01, in_ch.a02, in_ch.a10, in_ch.a11, in_ch.a12,
         in_ch.a20, in_ch.a21, in_ch.a22} = '0;
        out_ch.ready = 1'b0;
        build_directed();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed[i]) run_item(directed[i].m, directed[i].fixed_exp, directed[i].exp);
        for (int p = 0; p < 4; p++) begin
            send_idle_pct = phase_pct[p][0];
            recv_stall_pct = phase_pct[p][1];
            for (int n = 0; n < 270; n++) begin
                for (int k = 0; k < NUM_ELEM; k++) m.a[k] = rand_elem();
                // some near-singular matrices: row 2 = row 0 + row 1, half of them one bit off
                if ($urandom_range(0, 9) == 0) begin
                    for (int k = 0; k < 3; k++) m.a[6 + k] = m.a[k] + m.a[3 + k];
                    if ($urandom_range(0, 1)) m.a[8] = m.a[8] ^ 1;
                end
                run_item(m, 1'b0, '{default: '0});
            end
        end
        in_ch.valid <= 1'b0;
        recv_stall_pct = 0;
        tail = 0;
        while (pending_inv.size() != 0) @(posedge i_clk);
        while (tail < 3 * EW + 20) begin
            @(posedge i_clk);
            tail++;
        end
        if (mismatches == 0 && pending_inv.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/m3i_pkg.sv
rtl/m3i_ifs.sv
rtl/m3i_front.sv
rtl/m3i_div_step.sv
rtl/m3i_sat.sv
rtl/matrix3x3_inverse_unit.sv
bench/matrix3x3_inverse_unit_test.sv
